// ===== design/sto_pkg.sv =====
`timescale 1ns / 1ps

package sto_pkg;

  localparam int ACC_BITS_DEF         = 32;
  localparam int TABLE_INDEX_BITS_DEF = 12;
  localparam int SAMPLE_BITS_DEF      = 16;
  localparam int STEP_BITS            = 32;
  localparam int SERIES_TERMS         = 20;

  // pi/2 in unsigned Q2.62
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;

  // floor(2^75 / d) + 1 for d = 2n(2n+1), n = 1..20; exact floor division of 64-bit terms
  localparam int           RCP_SHIFT = 75;
  localparam logic [127:0] RCP_ONE   = 128'd1 << RCP_SHIFT;
  localparam logic [79:0]  SERIES_RCP [SERIES_TERMS] = '{
    80'(RCP_ONE / 128'd6    + 128'd1),
    80'(RCP_ONE / 128'd20   + 128'd1),
    80'(RCP_ONE / 128'd42   + 128'd1),
    80'(RCP_ONE / 128'd72   + 128'd1),
    80'(RCP_ONE / 128'd110  + 128'd1),
    80'(RCP_ONE / 128'd156  + 128'd1),
    80'(RCP_ONE / 128'd210  + 128'd1),
    80'(RCP_ONE / 128'd272  + 128'd1),
    80'(RCP_ONE / 128'd342  + 128'd1),
    80'(RCP_ONE / 128'd420  + 128'd1),
    80'(RCP_ONE / 128'd506  + 128'd1),
    80'(RCP_ONE / 128'd600  + 128'd1),
    80'(RCP_ONE / 128'd702  + 128'd1),
    80'(RCP_ONE / 128'd812  + 128'd1),
    80'(RCP_ONE / 128'd930  + 128'd1),
    80'(RCP_ONE / 128'd1056 + 128'd1),
    80'(RCP_ONE / 128'd1190 + 128'd1),
    80'(RCP_ONE / 128'd1332 + 128'd1),
    80'(RCP_ONE / 128'd1482 + 128'd1),
    80'(RCP_ONE / 128'd1640 + 128'd1)
  };

  function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b,
                                            int unsigned s, logic [63:0] rnd);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b} + {64'd0, rnd};
    p = p >> s;
    return p[63:0];
  endfunction

  function automatic logic [63:0] div_series(logic [63:0] t, int unsigned idx);
    logic [143:0] p;
    p = {80'd0, t} * {64'd0, SERIES_RCP[idx]};
    return p[RCP_SHIFT +: 64];
  endfunction

  // sin(x), x in [0, pi/2], Q2.62 in and out; Taylor series, exact integer steps
  function automatic logic [63:0] sine_q62(logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x2   = mul_shift(x, x, 62, 64'd0);
    term = x;
    sum  = x;
    for (int n = 1; n <= SERIES_TERMS; n++) begin
      term = div_series(mul_shift(term, x2, 62, 64'd0), n - 1);
      if (n % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // Rounded, clamped quarter-wave magnitude for quarter offset m.
  function automatic logic [63:0] quarter_mag(int unsigned m, int unsigned qbits,
                                              int unsigned sbits);
    logic [63:0] amp;
    logic [63:0] x;
    logic [63:0] s;
    logic [63:0] mag;
    amp = (64'd1 << (sbits - 1)) - 64'd1;
    x   = mul_shift(HALF_PI_Q62, 64'(m), qbits, 64'd0);
    s   = sine_q62(x);
    mag = mul_shift(amp, s, 62, 64'd1 << 61);
    if (mag > amp) begin
      mag = amp;
    end
    return mag;
  endfunction

endpackage

// ===== design/sto_if.sv =====
`timescale 1ns / 1ps

interface sto_in_if;
  logic valid;
  logic ready;
  logic end_of_buffer;

  modport source (output valid, output end_of_buffer, input ready);
  modport sink   (input valid, input end_of_buffer, output ready);
endinterface

interface sto_out_if #(
  parameter int SAMPLE_BITS = sto_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

// ===== design/sine_tone_oscillator_unit.sv =====
`timescale 1ns / 1ps
// Pipeline: stage one (ROM address), stage two (ROM read register), then the output register.
// Throughput: one beat per cycle while the receiver holds out_o.ready high.
// Stages collapse bubbles, so input stays ready while an output beat waits and space remains.
// Reset (async, active low): phase accumulator and phase step cleared, pipeline emptied.
module sine_tone_oscillator_unit #(
  parameter int ACC_BITS         = sto_pkg::ACC_BITS_DEF,
  parameter int TABLE_INDEX_BITS = sto_pkg::TABLE_INDEX_BITS_DEF,
  parameter int SAMPLE_BITS      = sto_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          phase_step_we_i,
  input  logic [sto_pkg::STEP_BITS-1:0] phase_step_i,
  sto_in_if.sink                        in_i,
  sto_out_if.source                     out_o
);
  import sto_pkg::*;

  localparam int QUARTER_BITS = TABLE_INDEX_BITS - 2;
  localparam int ADDR_BITS    = QUARTER_BITS + 1;
  localparam int QDEPTH       = (1 << QUARTER_BITS) + 1;
  localparam int MAG_BITS     = SAMPLE_BITS - 1;
  localparam logic [ADDR_BITS-1:0] QUARTER = ADDR_BITS'(1 << QUARTER_BITS);

  typedef logic [MAG_BITS-1:0] rom_t [QDEPTH];

  function automatic rom_t build_rom();
    rom_t t;
    for (int i = 0; i < QDEPTH; i++) begin
      t[i] = MAG_BITS'(quarter_mag(i, QUARTER_BITS, SAMPLE_BITS));
    end
    return t;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic [STEP_BITS-1:0]        step_q;
  logic [ACC_BITS-1:0]         acc_q, acc_d, step_ext;
  logic [TABLE_INDEX_BITS-1:0] k;
  logic [QUARTER_BITS-1:0]     r;
  logic [ADDR_BITS-1:0]        addr_d;

  logic                 s1_v_q, s1_neg_q, s1_last_q;
  logic [ADDR_BITS-1:0] s1_addr_q;
  logic                 s2_v_q, s2_neg_q, s2_last_q;
  logic [MAG_BITS-1:0]  s2_mag_q;
  logic                 out_v_q, out_last_q;
  logic [SAMPLE_BITS-1:0] out_sample_q, out_sample_d, mag_ext;

  logic in_fire, adv3, load3, en2, load2, en1;

  assign adv3  = !out_v_q || out_o.ready;
  assign load3 = s2_v_q && adv3;
  assign en2   = !s2_v_q || load3;
  assign load2 = s1_v_q && en2;
  assign en1   = !s1_v_q || load2;

  assign in_i.ready = en1;
  assign in_fire    = in_i.valid && en1;

  assign step_ext = ACC_BITS'(step_q);
  assign acc_d    = acc_q + step_ext;
  assign k        = acc_q[ACC_BITS-1 -: TABLE_INDEX_BITS];
  assign r        = k[QUARTER_BITS-1:0];
  assign addr_d   = k[QUARTER_BITS] ? (QUARTER - {1'b0, r}) : {1'b0, r};

  assign mag_ext      = {1'b0, s2_mag_q};
  assign out_sample_d = s2_neg_q ? (SAMPLE_BITS'(0) - mag_ext) : mag_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      acc_q   <= '0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (phase_step_we_i) begin
        step_q <= phase_step_i;
      end
      if (in_fire) begin
        acc_q <= acc_d;
      end
      if (en1) begin
        s1_v_q <= in_i.valid;
      end
      if (en2) begin
        s2_v_q <= s1_v_q;
      end
      if (adv3) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_addr_q <= addr_d;
      s1_neg_q  <= k[TABLE_INDEX_BITS-1];
      s1_last_q <= in_i.end_of_buffer;
    end
    if (load2) begin
      s2_mag_q  <= SINE_ROM[s1_addr_q];
      s2_neg_q  <= s1_neg_q;
      s2_last_q <= s1_last_q;
    end
    if (load3) begin
      out_sample_q <= out_sample_d;
      out_last_q   <= s2_last_q;
    end
  end

  assign out_o.valid  = out_v_q;
  assign out_o.sample = signed'(out_sample_q);
  assign out_o.last   = out_last_q;

  a_acc_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> acc_q == $past(acc_q + step_ext))
    else $error("phase accumulator did not advance by the step");

  a_acc_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> $stable(acc_q))
    else $error("phase accumulator moved without an input beat");

  a_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q |-> s1_addr_q <= QUARTER)
    else $error("quarter-wave address out of range");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !en1) |=> (s1_v_q && $stable(s1_addr_q) && $stable(s1_neg_q)))
    else $error("stalled stage one lost its contents");

  a_no_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> out_sample_q != {1'b1, {MAG_BITS{1'b0}}})
    else $error("sample reached the negative full-scale code");

endmodule

// ===== bench/sine_tone_oscillator_unit_tb.sv =====
`timescale 1ns / 1ps

module sine_tone_oscillator_unit_tb;

  localparam logic [63:0] QTR_TURN_Q62 = 64'h6487_ED51_10B4_611A;
  localparam logic [63:0] PEAK_CODE    = 64'd32767;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
  } tone_beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        phase_step_we_i;
  logic [31:0] phase_step_i;

  sto_in_if                      in_if ();
  sto_out_if #(.SAMPLE_BITS(16)) out_if ();

  sine_tone_oscillator_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .phase_step_we_i (phase_step_we_i),
    .phase_step_i    (phase_step_i),
    .in_i            (in_if),
    .out_o           (out_if)
  );

  logic [15:0] quarter_wave [0:1024];
  logic [31:0] phase_acc;
  logic [31:0] phase_inc;
  tone_beat_t  pending_beats [$];
  tone_beat_t  head_beat;
  int unsigned errors;
  bit          steady;
  int unsigned stall_left;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic logic [63:0] q62_mul(logic [63:0] a, logic [63:0] b,
                                          int unsigned sh, logic [63:0] bias);
    logic [127:0] wide;
    wide = ({64'd0, a} * {64'd0, b}) + {64'd0, bias};
    wide = wide >> sh;
    return wide[63:0];
  endfunction

  // sine of one quarter-turn offset, Taylor series in Q2.62, rounded half up
  function automatic logic [15:0] quarter_level(int unsigned m);
    logic [63:0] ang;
    logic [63:0] ang_sq;
    logic [63:0] tm;
    logic [63:0] acc;
    logic [63:0] mag;
    ang    = q62_mul(QTR_TURN_Q62, 64'(m), 10, 64'd0);
    ang_sq = q62_mul(ang, ang, 62, 64'd0);
    tm     = ang;
    acc    = ang;
    for (int n = 1; n <= 20; n++) begin
      tm  = q62_mul(tm, ang_sq, 62, 64'd0) / 64'((2 * n) * (2 * n + 1));
      acc = (n % 2 == 1) ? acc - tm : acc + tm;
    end
    mag = q62_mul(PEAK_CODE, acc, 62, 64'd1 << 61);
    if (mag > PEAK_CODE) begin
      mag = PEAK_CODE;
    end
    return mag[15:0];
  endfunction

  function automatic tone_beat_t next_tone(logic eob);
    logic [11:0] k;
    logic [10:0] m;
    logic [15:0] mag;
    tone_beat_t  b;
    k        = phase_acc[31:20];
    m        = k[10] ? 11'd1024 - {1'b0, k[9:0]} : {1'b0, k[9:0]};
    mag      = quarter_wave[m];
    b.sample = k[11] ? -mag : mag;
    b.last   = eob;
    phase_acc = phase_acc + phase_inc;
    return b;
  endfunction

  function automatic int unsigned sender_gap();
    int unsigned r;
    if (steady) begin
      return 0;
    end
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic int unsigned stall_len();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 70) return $urandom_range(2, 1);
    if (r < 95) return $urandom_range(8, 3);
    return $urandom_range(60, 20);
  endfunction

  // receiver backpressure
  initial begin
    out_if.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        if (!steady && $urandom_range(99, 0) < 15) begin
          stall_left = stall_len();
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected beat, sample %0d last %0b", $time,
                 $signed(out_if.sample), out_if.last);
        errors++;
      end else begin
        head_beat = pending_beats.pop_front();
        if (out_if.sample !== head_beat.sample) begin
          $display("%0t: sample expected %0d actual %0d", $time,
                   $signed(head_beat.sample), $signed(out_if.sample));
          errors++;
        end
        if (out_if.last !== head_beat.last) begin
          $display("%0t: last expected %0b actual %0b", $time,
                   head_beat.last, out_if.last);
          errors++;
        end
      end
    end
  end

  task automatic send_tick(input logic eob);
    int unsigned idle;
    idle = sender_gap();
    if (idle > 0) begin
      in_if.valid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.end_of_buffer <= eob;
    do @(posedge clk_i); while (!in_if.ready);
    pending_beats.push_back(next_tone(eob));
  endtask

  task automatic set_step(input logic [31:0] step);
    in_if.valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    phase_step_we_i <= 1'b1;
    phase_step_i    <= step;
    @(posedge clk_i);
    phase_step_we_i <= 1'b0;
    phase_inc = step;
  endtask

  task automatic test_zero_step();
    send_tick(1'b0);
    send_tick(1'b1);
    set_step(32'd0);
    send_tick(1'b1);
    send_tick(1'b0);
  endtask

  task automatic test_quadrant_peaks();
    set_step(32'h4000_0000);
    for (int i = 0; i < 8; i++) begin
      send_tick(i[0]);
    end
  endtask

  task automatic test_half_turn();
    set_step(32'h8000_0000);
    for (int i = 0; i < 4; i++) begin
      send_tick(i == 3);
    end
  endtask

  task automatic test_fine_step();
    set_step(32'd1);
    repeat (3) send_tick(1'b0);
    set_step(32'h0010_0001);
    repeat (4) send_tick(1'b1);
  endtask

  task automatic test_random_tones();
    logic [31:0] step;
    for (int p = 0; p < 9; p++) begin
      case (p)
        1: step = $urandom_range(32'h00FF_FFFF, 0);
        2: step = 32'h8000_0000 - $urandom_range(15, 0);
        4: step = 32'h8000_0000;
        6: step = $urandom_range(32'h0003_FFFF, 32'h0001_0000);
        default: step = $urandom_range(32'h8000_0000, 0);
      endcase
      steady = (p == 3 || p == 7);
      set_step(step);
      repeat (200) send_tick($urandom_range(7, 0) == 0);
    end
    steady = 1'b0;
  endtask

  task automatic finish_run();
    int unsigned waited;
    waited = 0;
    in_if.valid <= 1'b0;
    while (pending_beats.size() != 0 && waited < 50000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (10) @(posedge clk_i);
    if (pending_beats.size() != 0) begin
      $display("%0t: %0d beats never arrived", $time, pending_beats.size());
      errors++;
    end
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  endtask

  initial begin
    rst_ni              = 1'b0;
    phase_step_we_i     = 1'b0;
    phase_step_i        = 32'd0;
    in_if.valid         = 1'b0;
    in_if.end_of_buffer = 1'b0;
    errors              = 0;
    steady              = 1'b0;
    phase_acc           = 32'd0;
    phase_inc           = 32'd0;
    for (int m = 0; m <= 1024; m++) begin
      quarter_wave[m] = quarter_level(m);
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_zero_step();
    test_quadrant_peaks();
    test_half_turn();
    test_fine_step();
    test_random_tones();
    finish_run();
  end

endmodule

// ===== files.f =====
design/sto_pkg.sv
design/sto_if.sv
design/sine_tone_oscillator_unit.sv
bench/sine_tone_oscillator_unit_tb.sv
